// File: rtl/zapm_pkg.sv
// Package for the Z-algorithm pattern matcher: payload widths, item kind codes
// and the record passed from the cell row to the output stage.
// No dependencies.
package zapm_pkg;

    localparam int unsigned CH_W  = 8;   // pattern and text byte width
    localparam int unsigned POS_W = 16;  // width of reported text positions

    // Item kind codes on the input channel.
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // One item in flight between the cell row and the output register.
    typedef struct packed {
        logic             valid;
        logic             is_text;
        logic             ok;       // pattern non-empty and window filled
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] pos;
    } t_stage;

endpackage

// File: rtl/zapm_in_if.sv
// Input channel of the pattern matcher: valid/ready plus kind, ch, start_req.
// Depends on zapm_pkg.
interface zapm_in_if
    import zapm_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] ch;
    logic            start_req;

    modport source (output valid, kind, ch, start_req, input ready);
    modport sink   (input valid, kind, ch, start_req, output ready);
endinterface

// File: rtl/zapm_out_if.sv
// Result channel of the pattern matcher: valid/ready plus match, match_pos,
// text_index. Depends on zapm_pkg.
interface zapm_out_if
    import zapm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             match;
    logic [POS_W-1:0] match_pos;
    logic [POS_W-1:0] text_index;

    modport source (output valid, match, match_pos, text_index, input ready);
    modport sink   (input valid, match, match_pos, text_index, output ready);
endinterface

// File: rtl/zapm_cell.sv
// One cell of the matcher row: holds one pattern byte and one text byte,
// shifts both toward its neighbor, and registers its own byte compare.
// Depends on zapm_pkg.
module zapm_cell
    import zapm_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned LW  = 7
) (
    input  logic            i_clk,
    input  logic            i_pat_shift,
    input  logic            i_txt_shift,
    input  logic [CH_W-1:0] i_pat,
    input  logic [CH_W-1:0] i_txt,
    input  logic [LW-1:0]   i_len,
    output logic [CH_W-1:0] o_pat,
    output logic [CH_W-1:0] o_txt,
    output logic            o_eq
);

    logic [CH_W-1:0] r_pat;
    logic [CH_W-1:0] r_txt;
    logic            r_eq;

    // A cell at or beyond the pattern length does not take part in the match.
    always_ff @(posedge i_clk) begin
        if (i_pat_shift) begin
            r_pat <= i_pat;
        end
        if (i_txt_shift) begin
            r_txt <= i_txt;
            r_eq  <= (i_txt == r_pat) || (i_len <= LW'(IDX));
        end
    end

    assign o_pat = r_pat;
    assign o_txt = r_txt;
    assign o_eq  = r_eq;

endmodule

// File: rtl/zapm_out.sv
// Output stage of the matcher: reduces the per-cell compares of the item in
// flight and holds the result item in the output register. Depends on zapm_pkg.
module zapm_out
    import zapm_pkg::*;
#(
    parameter int unsigned N = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_stage         i_s1,
    input  logic [N-1:0]   i_eq,
    output logic           o_take,
    zapm_out_if.source     o_res
);

    logic             r_valid;
    logic             r_match;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_idx;
    logic             hit;

    assign o_take = !r_valid || o_res.ready;
    assign hit    = i_s1.is_text && i_s1.ok && (&i_eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_match <= hit;
            r_pos   <= hit ? i_s1.pos : '0;
            r_idx   <= i_s1.is_text ? i_s1.idx : '0;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.match      = r_match;
    assign o_res.match_pos  = r_pos;
    assign o_res.text_index = r_idx;

endmodule

// File: rtl/z_algorithm_pattern_match_core.sv
// Top level of the streaming exact pattern matcher (Z-algorithm result set).
// Depends on zapm_pkg, zapm_in_if, zapm_out_if, zapm_cell and zapm_out.
//
// Channel | Dir | Payload                               | Item
// i_in    | in  | kind, ch[7:0], start_req              | one pattern or text byte
// o_res   | out | match, match_pos[15:0], text_index    | one result per input item
//
// An accepted item is registered in the cell row and r_s1 first, and then in
// the output register that drives o_res. A new item is accepted every cycle
// while o_res takes results; the row of PAT_MAX cells compares the whole
// window in parallel, so the pattern length does not slow the stream. A stall
// on o_res holds the output register and the item behind it, and i_in.ready
// drops until the output register is taken. Reset clears the pattern length,
// text counters and pipeline valid bits.
module z_algorithm_pattern_match_core
    import zapm_pkg::*;
#(
    parameter int unsigned      PAT_MAX  = 64,
    parameter longint unsigned  TEXT_MAX = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zapm_in_if.sink     i_in,
    zapm_out_if.source  o_res
);

    localparam int unsigned LW = $clog2(PAT_MAX + 1);
    localparam int unsigned IW = $clog2(TEXT_MAX);
    // Common width for the start-position arithmetic, with room for TEXT_MAX.
    localparam int unsigned CW = ((IW > LW) ? IW : LW) + 2;

    // Pattern length, text index of the next byte and window fill level.
    logic [LW-1:0] r_len, n_len;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_fill, n_fill;
    t_stage        r_s1, n_s1;

    logic                    take;
    logic                    acc;
    logic                    pat_acc;
    logic                    txt_acc;
    logic                    pat_shift;
    logic                    len_full;
    logic [LW-1:0]           fill_base;
    logic [IW-1:0]           idx;
    logic [CW-1:0]           idx_w;
    logic [CW-1:0]           back_w;
    logic [CW-1:0]           pos_w;
    logic [63:0]             idx_64;
    logic [63:0]             pos_64;

    // Cell chain wiring: element k feeds cell k, element 0 takes the new byte.
    logic [CH_W-1:0] pat_chain [PAT_MAX+1];
    logic [CH_W-1:0] txt_chain [PAT_MAX+1];
    logic [PAT_MAX-1:0] eq;

    assign i_in.ready = take;
    assign acc        = i_in.valid && take;
    assign pat_acc    = acc && (i_in.kind == KIND_PATTERN);
    assign txt_acc    = acc && (i_in.kind == KIND_TEXT);
    assign len_full   = (r_len == LW'(PAT_MAX));
    // Bytes past a full pattern are dropped and do not disturb the row.
    assign pat_shift  = pat_acc && (i_in.start_req || !len_full);

    assign pat_chain[0] = i_in.ch;
    assign txt_chain[0] = i_in.ch;

    // The row keeps the pattern reversed: after loading p0..p(L-1), cell k
    // holds p(L-1-k), and cell k of the text row holds the k-th newest byte,
    // so a match needs each cell below L to agree with itself.
    for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
        zapm_cell #(
            .IDX (k),
            .LW  (LW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_pat_shift (pat_shift),
            .i_txt_shift (txt_acc),
            .i_pat       (pat_chain[k]),
            .i_txt       (txt_chain[k]),
            .i_len       (r_len),
            .o_pat       (pat_chain[k+1]),
            .o_txt       (txt_chain[k+1]),
            .o_eq        (eq[k])
        );
    end

    // Text bookkeeping for the accepted byte: its index, the start of an
    // occurrence that would end here, and whether the window is full enough.
    always_comb begin
        idx       = i_in.start_req ? '0 : r_cnt;
        fill_base = i_in.start_req ? '0 : r_fill;
        idx_w     = CW'(idx);
        back_w    = CW'(r_len) - CW'(1);
        if (idx_w >= back_w) begin
            pos_w = idx_w - back_w;
        end else begin
            pos_w = idx_w + CW'(TEXT_MAX) - back_w;
        end
        idx_64 = 64'(idx);
        pos_64 = 64'(pos_w);

        n_len  = r_len;
        n_cnt  = r_cnt;
        n_fill = r_fill;
        if (pat_acc) begin
            if (i_in.start_req) begin
                n_len = LW'(1);
            end else if (!len_full) begin
                n_len = r_len + LW'(1);
            end
        end
        if (txt_acc) begin
            n_cnt  = (idx == IW'(TEXT_MAX - 1)) ? '0 : idx + IW'(1);
            n_fill = (fill_base == LW'(PAT_MAX)) ? fill_base : fill_base + LW'(1);
        end

        n_s1         = r_s1;
        if (take) begin
            n_s1.valid   = acc;
            n_s1.is_text = (i_in.kind == KIND_TEXT);
            n_s1.ok      = (r_len != '0) && (n_fill >= r_len);
            n_s1.idx     = idx_64[POS_W-1:0];
            n_s1.pos     = pos_64[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_cnt        <= '0;
            r_fill       <= '0;
            r_s1         <= '0;
        end else begin
            r_len        <= n_len;
            r_cnt        <= n_cnt;
            r_fill       <= n_fill;
            r_s1         <= n_s1;
        end
    end

    zapm_out #(
        .N (PAT_MAX)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (r_s1),
        .i_eq    (eq),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule

// File: rtl/zapm_checker.sv
// Port-level checks for the pattern matcher, bound to the top level.
// Depends on zapm_pkg and z_algorithm_pattern_match_core.
module zapm_checker
    import zapm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_match,
    input logic [POS_W-1:0] i_match_pos,
    input logic [POS_W-1:0] i_text_index
);

    // A result that is not taken stays and keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_match) && $stable(i_match_pos) &&
            $stable(i_text_index))
        else $error("result changed while stalled");

    // A miss never reports a start position.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_match |-> i_match_pos == '0)
        else $error("match_pos set without a match");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An accepted item is followed by a valid result on the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("accepted item produced no result in time");

endmodule

bind z_algorithm_pattern_match_core zapm_checker u_zapm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_match      (o_res.match),
    .i_match_pos  (o_res.match_pos),
    .i_text_index (o_res.text_index)
);

// File: tb/tb.sv
// Self-checking bench for z_algorithm_pattern_match_core: streams pattern and text bytes,
// predicts every match result on the side and checks each result as it is taken.
// Depends on zapm_pkg, zapm_in_if, zapm_out_if and the core itself.
module tb
    import zapm_pkg::*;
;

    localparam int unsigned PAT_MAX     = 64;
    localparam int unsigned TEXT_MAX    = 65536;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned MAX_REPORTS = 10;

    localparam bit [CH_W-1:0] CH_A   = 8'h61;
    localparam bit [CH_W-1:0] CH_B   = 8'h62;
    localparam bit [CH_W-1:0] CH_SEP = 8'h24;   // the separator byte

    typedef struct packed {
        logic             match;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] idx;
    } t_result;

    // Tracks the matcher state and holds the results still owed by the block.
    class match_ledger;
        bit [CH_W-1:0] pat_bytes [PAT_MAX];
        int unsigned   pat_len;
        bit [CH_W-1:0] window [PAT_MAX];   // window[0] holds the newest text byte
        int unsigned   fill;
        int unsigned   next_idx;
        t_result       awaited [$];
        int unsigned   mismatches;

        function new();
            pat_len    = 0;
            fill       = 0;
            next_idx   = 0;
            mismatches = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function t_result predict_occurrence(logic kind, logic [CH_W-1:0] ch, logic start);
            t_result     r;
            int unsigned idx;
            int unsigned i;
            bit          hit;
            r = '0;
            if (kind == KIND_PATTERN) begin
                if (start) pat_len = 0;
                // Bytes past the store size are dropped; the length saturates.
                if (pat_len < PAT_MAX) begin
                    pat_bytes[pat_len] = ch;
                    pat_len++;
                end
                return r;
            end
            if (start) begin
                next_idx = 0;
                fill     = 0;
            end
            idx = next_idx;
            for (i = PAT_MAX - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = ch;
            if (fill < PAT_MAX) fill++;
            // An empty pattern or a text shorter than the pattern never matches.
            hit = (pat_len != 0) && (fill >= pat_len);
            for (i = 0; hit && i < pat_len; i++) begin
                if (pat_bytes[i] != window[pat_len-1-i]) hit = 1'b0;
            end
            if (hit) begin
                r.match = 1'b1;
                r.pos   = POS_W'((idx + TEXT_MAX - (pat_len - 1)) % TEXT_MAX);
            end
            r.idx    = POS_W'(idx);
            next_idx = (idx + 1) % TEXT_MAX;
            return r;
        endfunction

        function void note_byte(logic kind, logic [CH_W-1:0] ch, logic start);
            t_result r;
            r       = predict_occurrence(kind, ch, start);
            awaited = {awaited, r};
        endfunction

        function void check_result(logic m, logic [POS_W-1:0] p, logic [POS_W-1:0] x);
            t_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result match=%0d pos=%0d index=%0d", m, p, x);
                return;
            end
            want = awaited.pop_front();
            if (m !== want.match || p !== want.pos || x !== want.idx) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: expected match=%0d pos=%0d index=%0d, got %0d/%0d/%0d",
                             want.match, want.pos, want.idx, m, p, x);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned src_idle_pct = 28;
    int unsigned snk_idle_pct = 48;
    bit [CH_W-1:0] gen_pat [$];   // the pattern as the generator last loaded it
    match_ledger ledger;

    zapm_in_if  in_ch ();
    zapm_out_if res_ch ();

    z_algorithm_pattern_match_core #(
        .PAT_MAX  (PAT_MAX),
        .TEXT_MAX (TEXT_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: take what is offered, stall at random, check each taken result.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            ledger.check_result(res_ch.match, res_ch.match_pos, res_ch.text_index);
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic push_item(input logic kind, input logic [CH_W-1:0] ch, input logic start);
        if (items_sent < 220) begin
            src_idle_pct = 28;
            snk_idle_pct = 48;
        end else if (items_sent < 420) begin
            src_idle_pct = 48;
            snk_idle_pct = 28;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.ch        <= ch;
        in_ch.start_req <= start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        ledger.note_byte(kind, ch, start);
        items_sent++;
    endtask

    // Mostly a small alphabet with the separator, so that matches are common.
    function automatic bit [CH_W-1:0] pick_byte(bit narrow);
        int unsigned r;
        r = $urandom_range(9);
        if (!narrow || r == 9) return CH_W'($urandom_range(255));
        if (r < 4) return CH_A;
        if (r < 8) return CH_B;
        return CH_SEP;
    endfunction

    task automatic run_directed();
        push_item(KIND_TEXT, 8'h00, 1'b1);       // nothing loaded yet: no match
        push_item(KIND_PATTERN, 8'hFF, 1'b1);
        push_item(KIND_TEXT, 8'hFF, 1'b0);
        push_item(KIND_TEXT, 8'h00, 1'b0);
        push_item(KIND_PATTERN, CH_A, 1'b1);     // reload while the text goes on
        push_item(KIND_PATTERN, CH_B, 1'b0);
        push_item(KIND_TEXT, CH_A, 1'b0);
        push_item(KIND_TEXT, CH_B, 1'b0);
        push_item(KIND_TEXT, CH_SEP, 1'b0);
        push_item(KIND_TEXT, CH_A, 1'b0);
        push_item(KIND_TEXT, CH_B, 1'b0);
        push_item(KIND_TEXT, CH_A, 1'b0);
        // A restarted text cannot match this two-byte pattern on its first byte, whatever the window still holds.
        push_item(KIND_TEXT, CH_B, 1'b1);
        push_item(KIND_PATTERN, CH_SEP, 1'b1);
        push_item(KIND_TEXT, CH_SEP, 1'b0);
        push_item(KIND_PATTERN, CH_A, 1'b1);
        push_item(KIND_PATTERN, CH_A, 1'b0);
        push_item(KIND_TEXT, CH_A, 1'b0);       // overlapping occurrences
        push_item(KIND_TEXT, CH_A, 1'b0);
        push_item(KIND_TEXT, CH_A, 1'b0);
    endtask

    // One pattern load followed by text seeded with copies of that pattern, or a short burst of random items.
    task automatic random_episode(input bit force_long);
        int unsigned r;
        int unsigned plen;
        int unsigned tlen;
        int unsigned n;
        int unsigned k;
        int unsigned cut;
        bit          narrow;
        bit          restart;
        bit [CH_W-1:0] b;
        if (!force_long && $urandom_range(99) < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) push_item(1'($urandom_range(1)), CH_W'($urandom_range(255)),
                                 1'($urandom_range(1)));
            return;
        end
        narrow = ($urandom_range(99) < 75);
        r = $urandom_range(99);
        if (force_long)  plen = 70;
        else if (r < 85) plen = $urandom_range(1, 6);
        else if (r < 95) plen = $urandom_range(7, 20);
        else             plen = $urandom_range(60, 70);
        gen_pat.delete();
        for (k = 0; k < plen; k++) begin
            b = pick_byte(narrow);
            if (k < PAT_MAX) gen_pat = {gen_pat, b};
            push_item(KIND_PATTERN, b, k == 0);
        end
        tlen    = (plen > 20) ? $urandom_range(plen, 2 * plen + 10) : $urandom_range(4, 30);
        restart = ($urandom_range(99) < 70);
        n = 0;
        while (n < tlen) begin
            if ($urandom_range(99) < 35) begin
                cut = ($urandom_range(99) < 80) ? gen_pat.size()
                                                : $urandom_range(1, gen_pat.size());
                for (k = 0; k < cut; k++) begin
                    push_item(KIND_TEXT, gen_pat[k], restart || $urandom_range(99) < 2);
                    restart = 1'b0;
                    n++;
                end
            end else begin
                push_item(KIND_TEXT, pick_byte(narrow), restart || $urandom_range(99) < 2);
                restart = 1'b0;
                n++;
            end
        end
    endtask

    initial begin
        int unsigned episode;
        ledger = new();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= KIND_PATTERN;
        in_ch.ch        <= '0;
        in_ch.start_req <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        episode = 0;
        while (items_sent < 560) begin
            random_episode(episode == 4);
            episode++;
        end
        in_ch.valid <= 1'b0;

        // Drain, then give the two-stage pipe time to show any stray result.
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/zapm_pkg.sv
rtl/zapm_in_if.sv
rtl/zapm_out_if.sv
rtl/zapm_cell.sv
rtl/zapm_out.sv
rtl/z_algorithm_pattern_match_core.sv
rtl/zapm_checker.sv
tb/tb.sv
